@@ design/bswl_pkg.sv @@
// bswl_pkg: shared types and constants for bars_since_window_low.
// Holds the sequencer state type, the scan request/response structs and fixed widths.
// No dependencies.
package bswl_pkg;

  localparam int WLEN_W = 9;   // window length register and scan age width
  localparam int CNT_W  = 16;  // counts and result width

  localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd20;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              go;
    logic [WLEN_W-1:0] top_age;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic [WLEN_W-1:0] best_age;
  } scan_rsp_t;

endpackage

@@ design/bswl_ifs.sv @@
// bswl_ifs: valid/ready channel interfaces for bars_since_window_low.
// Sample channel carries one price sample per beat; result channel one count per beat.
// No dependencies.
interface bswl_in_if #(parameter int SAMPLE_BITS = 32);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] price;
  logic                   series_start;
  logic                   in_discard;

  modport source (output valid, price, series_start, in_discard, input ready);
  modport sink   (input valid, price, series_start, in_discard, output ready);
endinterface

interface bswl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bars_since_low;
  logic        out_valid;

  modport source (output valid, bars_since_low, out_valid, input ready);
  modport sink   (input valid, bars_since_low, out_valid, output ready);
endinterface

@@ design/bswl_scan.sv @@
// bswl_scan: sample store and shared compare unit that walks the window oldest to newest.
// One store read per cycle, registered; a "<=" compare keeps the latest lowest sample.
// Depends on bswl_pkg.
module bswl_scan #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WINDOW)-1:0] wr_addr,
  input  logic [SAMPLE_BITS-1:0]        wr_data,
  input  logic [$clog2(MAX_WINDOW)-1:0] start_ptr,
  input  bswl_pkg::scan_req_t           req,
  output bswl_pkg::scan_rsp_t           rsp
);

  localparam int PW = $clog2(MAX_WINDOW);

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

  logic                        busy_r, busy_nxt;
  logic [PW-1:0]               ptr_r, ptr_nxt;
  logic [bswl_pkg::WLEN_W-1:0] age_r, age_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic                        rd_last_r, rd_last_nxt;
  logic [bswl_pkg::WLEN_W-1:0] rd_age_r, rd_age_nxt;
  logic [SAMPLE_BITS-1:0]      rd_data_r;
  logic                        first_r, first_nxt;
  logic [SAMPLE_BITS-1:0]      best_r, best_nxt;
  logic [bswl_pkg::WLEN_W-1:0] best_age_r, best_age_nxt;
  logic                        done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (busy_r) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    ptr_nxt      = ptr_r;
    age_nxt      = age_r;
    first_nxt    = first_r;
    best_nxt     = best_r;
    best_age_nxt = best_age_r;
    rd_vld_nxt   = busy_r;
    rd_age_nxt   = age_r;
    rd_last_nxt  = (age_r == '0);
    done_nxt     = rd_vld_r && rd_last_r;

    if (rd_vld_r) begin
      if (first_r || ($signed(rd_data_r) <= $signed(best_r))) begin
        best_nxt     = rd_data_r;
        best_age_nxt = rd_age_r;
      end
      first_nxt = 1'b0;
    end

    if (req.go) begin
      busy_nxt  = 1'b1;
      ptr_nxt   = start_ptr;
      age_nxt   = req.top_age;
      first_nxt = 1'b1;
    end else if (busy_r) begin
      // advance toward the newest sample, wrap at the end of the store
      ptr_nxt  = (ptr_r == PW'(MAX_WINDOW - 1)) ? '0 : ptr_r + 1'b1;
      age_nxt  = age_r - 1'b1;
      busy_nxt = (age_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      done_r   <= 1'b0;
      first_r  <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      rd_vld_r <= rd_vld_nxt;
      done_r   <= done_nxt;
      first_r  <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    age_r      <= age_nxt;
    rd_age_r   <= rd_age_nxt;
    rd_last_r  <= rd_last_nxt;
    best_r     <= best_nxt;
    best_age_r <= best_age_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.best_age = best_age_r;

endmodule

@@ design/bars_since_window_low.sv @@
// bars_since_window_low: top level; sequencer, running series low, window register, output beat.
// Depends on bswl_pkg, bswl_ifs (bswl_in_if, bswl_out_if) and bswl_scan.
//
// Usage:
//   in_ch carries one price sample per beat (price, series_start, in_discard);
//   out_ch returns one beat per sample: bars_since_low and out_valid.
//   cfg_wr_en/cfg_wr_data write window_len (0 = whole series); write only while idle.
// Timing:
//   The block takes one sample at a time; in_ch.ready is low while a sample is worked.
//   A windowed sample scans the last W entries of the sample store, where
//   W = min(window_len, MAX_WINDOW, samples in the series): the store is walked
//   one entry per cycle through a single read port and one compare unit.
//   Discarded samples and window_len 0 skip the scan and go straight to the result.
//   The next sample is accepted as soon as a result sits in the output register.
// Reset:
//   Synchronous, active low: history cleared, window_len back to 20, no beat pending.
//   The sample store needs no clearing; only entries of the current series are read.
// Stall:
//   A result holds in the output register while out_ch.ready is low; one more sample
//   may be worked meanwhile and then waits until the output register frees.
module bars_since_window_low #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bswl_in_if.sink                       in_ch,
  bswl_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [bswl_pkg::WLEN_W-1:0]   cfg_wr_data
);

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int CNT_W = bswl_pkg::CNT_W;

  bswl_pkg::state_t state_r, state_nxt;

  logic [bswl_pkg::WLEN_W-1:0] window_len_r;
  logic [SAMPLE_BITS-1:0]      price_r;
  logic                        start_r;
  logic                        discard_r;

  logic [SAMPLE_BITS-1:0] low_value_r, low_value_nxt;
  logic [CNT_W-1:0]       low_age_r, low_age_nxt;
  logic [CNT_W-1:0]       valid_count_r, valid_count_nxt;
  logic [PW-1:0]          write_ptr_r, write_ptr_nxt;

  logic [CNT_W-1:0] res_r, res_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [CNT_W-1:0] out_bars_r;
  logic             out_ok_r;
  logic             out_load;

  // series state after an optional series_start clear
  logic [SAMPLE_BITS-1:0] lv_base;
  logic [CNT_W-1:0]       la_base;
  logic [CNT_W-1:0]       vc_base;
  logic [PW-1:0]          wp_base;
  logic [CNT_W-1:0]       vc_inc;

  logic [CNT_W-1:0] w_len;
  logic [CNT_W-1:0] w_m1;
  logic [PW:0]      start_diff;
  logic [PW-1:0]    start_ptr;

  bswl_pkg::scan_req_t scan_req;
  bswl_pkg::scan_rsp_t scan_rsp;
  logic                mem_wr_en;

  assign in_ch.ready = (state_r == bswl_pkg::ST_IDLE);

  assign lv_base = start_r ? '0 : low_value_r;
  assign la_base = start_r ? '0 : low_age_r;
  assign vc_base = start_r ? '0 : valid_count_r;
  assign wp_base = start_r ? '0 : write_ptr_r;

  // count of valid samples once this one is stored, saturating
  assign vc_inc = (vc_base == bswl_pkg::CNT_MAX) ? vc_base : vc_base + 1'b1;

  // window length clamped to the store depth and to the samples seen so far
  always_comb begin
    w_len = CNT_W'(window_len_r);
    if (w_len > CNT_W'(MAX_WINDOW)) begin
      w_len = CNT_W'(MAX_WINDOW);
    end
    if (w_len > vc_inc) begin
      w_len = vc_inc;
    end
  end

  assign w_m1       = w_len - 1'b1;
  assign start_diff = {1'b0, wp_base} - w_m1[PW:0];
  assign start_ptr  = start_diff[PW] ? PW'(start_diff + (PW+1)'(MAX_WINDOW)) : start_diff[PW-1:0];

  assign out_load = (state_r == bswl_pkg::ST_DONE) && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt       = state_r;
    low_value_nxt   = low_value_r;
    low_age_nxt     = low_age_r;
    valid_count_nxt = valid_count_r;
    write_ptr_nxt   = write_ptr_r;
    res_nxt         = res_r;
    res_ok_nxt      = res_ok_r;
    scan_req.go      = 1'b0;
    scan_req.top_age = w_m1[bswl_pkg::WLEN_W-1:0];
    mem_wr_en        = 1'b0;

    case (state_r)
      bswl_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = bswl_pkg::ST_UPDATE;
        end
      end
      bswl_pkg::ST_UPDATE: begin
        low_value_nxt   = lv_base;
        low_age_nxt     = la_base;
        valid_count_nxt = vc_base;
        write_ptr_nxt   = wp_base;
        if (discard_r) begin
          res_nxt    = '0;
          res_ok_nxt = 1'b0;
          state_nxt  = bswl_pkg::ST_DONE;
        end else begin
          if ((vc_base == '0) || ($signed(price_r) <= $signed(lv_base))) begin
            low_value_nxt = price_r;
            low_age_nxt   = '0;
          end else if (la_base != bswl_pkg::CNT_MAX) begin
            low_age_nxt = la_base + 1'b1;
          end
          mem_wr_en       = 1'b1;
          write_ptr_nxt   = (wp_base == PW'(MAX_WINDOW - 1)) ? '0 : wp_base + 1'b1;
          valid_count_nxt = vc_inc;
          res_ok_nxt = 1'b1;
          if (window_len_r == '0) begin
            res_nxt   = low_age_nxt;
            state_nxt = bswl_pkg::ST_DONE;
          end else begin
            scan_req.go = 1'b1;
            state_nxt   = bswl_pkg::ST_SCAN;
          end
        end
      end
      bswl_pkg::ST_SCAN: begin
        if (scan_rsp.done) begin
          res_nxt   = CNT_W'(scan_rsp.best_age);
          state_nxt = bswl_pkg::ST_DONE;
        end
      end
      bswl_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = bswl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bswl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bswl_pkg::ST_IDLE;
      window_len_r  <= bswl_pkg::WLEN_RESET;
      low_value_r   <= '0;
      low_age_r     <= '0;
      valid_count_r <= '0;
      write_ptr_r   <= '0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      low_value_r   <= low_value_nxt;
      low_age_r     <= low_age_nxt;
      valid_count_r <= valid_count_nxt;
      write_ptr_r   <= write_ptr_nxt;
      out_vld_r     <= out_vld_nxt;
      if (cfg_wr_en) begin
        window_len_r <= cfg_wr_data;
      end
    end
  end

  // capture the sample beat; hold result payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      price_r   <= in_ch.price;
      start_r   <= in_ch.series_start;
      discard_r <= in_ch.in_discard;
    end
    res_r    <= res_nxt;
    res_ok_r <= res_ok_nxt;
    if (out_load) begin
      out_bars_r <= res_r;
      out_ok_r   <= res_ok_r;
    end
  end

  bswl_scan #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (mem_wr_en),
    .wr_addr   (wp_base),
    .wr_data   (price_r),
    .start_ptr (start_ptr),
    .req       (scan_req),
    .rsp       (scan_rsp)
  );

  assign out_ch.valid          = out_vld_r;
  assign out_ch.bars_since_low = out_bars_r;
  assign out_ch.out_valid      = out_ok_r;

endmodule

@@ design/bswl_checker.sv @@
// bswl_checker: port-level assertions for bars_since_window_low, attached by bind.
// Depends on bswl_ifs through the top level's channel ports.
module bswl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_vld,
  input logic        out_rdy,
  input logic [15:0] out_bars,
  input logic        out_ok
);

  // a beat that waits keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(out_bars) && $stable(out_ok))
    else $error("result beat changed while stalled");

  // an invalid result always reports a zero count
  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_ok |-> out_bars == 16'd0)
    else $error("discarded sample gave a nonzero count");

  // an accepted sample keeps in_ready low in UPDATE and in the state that follows it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("sample accepted while previous one in progress");

  // reset leaves no beat pending and the block ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_vld && in_ready)
    else $error("block not idle after reset");

endmodule

bind bars_since_window_low bswl_checker u_bswl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_vld  (out_ch.valid),
  .out_rdy  (out_ch.ready),
  .out_bars (out_ch.bars_since_low),
  .out_ok   (out_ch.out_valid)
);
